// File: rtl/core/pesc_pkg.sv
// Shared types, register indexes, constants and fixed-point helpers for the
// particle Euler step with sphere collision. No dependencies.
`default_nettype none

package pesc_pkg;

	// Fraction bits of the Q16.16 format.
	localparam int unsigned FRAC = 16;

	// Physical constants in Q16.16.
	localparam logic signed [20:0] GRAVITY_Q = -21'sd642253;
	localparam logic signed [20:0] BUOY_Q    = 21'sd655360;
	localparam logic signed [17:0] DAMP_Q    = 18'sd52429;
	localparam logic signed [32:0] PUSH_Q    = 33'sd655;
	localparam logic signed [17:0] ONE_Q     = 18'sd65536;

	// Step counts of the iterative units.
	localparam int SQRT_STEPS = 32;
	localparam int NDIV_STEPS = 17;
	localparam int GDIV_STEPS = 48;

	// Configuration register indexes.
	localparam logic [2:0] REG_TIME_STEP = 3'd0;
	localparam logic [2:0] REG_MODE      = 3'd1;
	localparam logic [2:0] REG_OBS_X     = 3'd2;
	localparam logic [2:0] REG_OBS_Y     = 3'd3;
	localparam logic [2:0] REG_OBS_Z     = 3'd4;
	localparam logic [2:0] REG_RADIUS    = 3'd5;
	localparam logic [2:0] REG_LIFESPAN  = 3'd6;

	localparam logic MODE_SMOKE = 1'b1;

	localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	// One particle request.
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [31:0] life_left;
	} in_t;

	// One updated particle.
	typedef struct packed {
		logic signed [31:0] new_px;
		logic signed [31:0] new_py;
		logic signed [31:0] new_pz;
		logic signed [31:0] new_vx;
		logic signed [31:0] new_vy;
		logic signed [31:0] new_vz;
		logic signed [31:0] new_life;
		logic signed [31:0] green;
		logic               green_valid;
		logic               dead;
		logic               collided;
	} out_t;

	// Configuration registers.
	typedef struct packed {
		logic [16:0]        time_step;
		logic               mode;
		logic signed [31:0] obs_x;
		logic signed [31:0] obs_y;
		logic signed [31:0] obs_z;
		logic [30:0]        radius;
		logic [30:0]        lifespan;
	} cfg_t;

	// Particle state carried from the motion stages to the collision stages.
	typedef struct packed {
		logic [2:0][31:0] p;
		logic [2:0][31:0] v;
		logic [2:0][32:0] d;
		logic [31:0]      new_life;
		logic             dead;
		logic             hit;
	} side_t;

	function automatic logic signed [63:0] ext32(input logic [31:0] x);
		return {{32{x[31]}}, x};
	endfunction

	// Saturate to the signed 32-bit range.
	function automatic logic [31:0] sat32(input logic signed [63:0] x);
		logic [31:0] r;
		if (x > 64'sd2147483647) begin
			r = SAT_MAX;
		end else if (x < -64'sd2147483648) begin
			r = SAT_MIN;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// Drop 16 fraction bits, rounding half up.
	function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
		logic signed [63:0] t;
		t = x + 64'sd32768;
		return t >>> FRAC;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/particle_euler_sphere_collide.sv
// Particle Euler step with one sphere obstacle; top level. Uses pesc_pkg,
// pesc_front, pesc_sqrt, pesc_ndiv, pesc_gdiv and pesc_back.
//
// A request on in_data (position, velocity, life, signed Q16.16) is taken
// when in_valid is high and in_stall is low. The updated particle appears on
// out_data with out_valid and is taken when out_stall is low.
// The pipeline has 5 motion and range-test stages, 32 square root
// stages, 17 normal divide stages and 4 collision stages; the smoke color
// divider runs 49 stages beside the root and normal divider.
// One request per cycle while not stalled; every stage holds one particle.
// When out_stall is high while a result waits, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears the valid bits and loads the register defaults. The user must
// write registers through cfg_we, cfg_index and cfg_data only while no
// particle is in flight (not enforced); index 7, past lifespan, is ignored.
`default_nettype none

module particle_euler_sphere_collide (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire pesc_pkg::in_t     in_data,
	output logic                   out_valid,
	input  wire                    out_stall,
	output pesc_pkg::out_t         out_data,
	input  wire                    cfg_we,
	input  wire [2:0]              cfg_index,
	input  wire [31:0]             cfg_data
);

	pesc_pkg::cfg_t  cfg_q;
	logic            en;

	logic            f_valid;
	pesc_pkg::side_t f_side;
	logic [63:0]     f_sum;
	logic [31:0]     f_life;

	logic            r_valid;
	pesc_pkg::side_t r_side;
	logic [31:0]     r_dis;

	logic            d_valid;
	pesc_pkg::side_t d_side;
	logic [2:0][16:0] d_q;
	logic            d_dzero;

	logic [31:0]     green;

	// The pipeline advances unless a finished result is held.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step <= 17'd1092;
			cfg_q.mode      <= 1'b0;
			cfg_q.obs_x     <= '0;
			cfg_q.obs_y     <= '0;
			cfg_q.obs_z     <= '0;
			cfg_q.radius    <= '0;
			cfg_q.lifespan  <= 31'd131072;
		end else if (cfg_we) begin
			case (cfg_index)
				pesc_pkg::REG_TIME_STEP: cfg_q.time_step <= cfg_data[16:0];
				pesc_pkg::REG_MODE:      cfg_q.mode      <= cfg_data[0];
				pesc_pkg::REG_OBS_X:     cfg_q.obs_x     <= cfg_data;
				pesc_pkg::REG_OBS_Y:     cfg_q.obs_y     <= cfg_data;
				pesc_pkg::REG_OBS_Z:     cfg_q.obs_z     <= cfg_data;
				pesc_pkg::REG_RADIUS:    cfg_q.radius    <= cfg_data[30:0];
				pesc_pkg::REG_LIFESPAN:  cfg_q.lifespan  <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	pesc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.out_valid (f_valid),
		.out_side  (f_side),
		.out_sum   (f_sum),
		.out_life  (f_life)
	);

	pesc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.in_side   (f_side),
		.in_sum    (f_sum),
		.out_valid (r_valid),
		.out_side  (r_side),
		.out_dis   (r_dis)
	);

	pesc_ndiv u_ndiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (r_valid),
		.in_side   (r_side),
		.in_dis    (r_dis),
		.out_valid (d_valid),
		.out_side  (d_side),
		.out_q     (d_q),
		.out_dzero (d_dzero)
	);

	// Runs beside the root and normal divider with the same latency.
	pesc_gdiv u_gdiv (
		.clk   (clk),
		.en    (en),
		.life  (f_life),
		.cfg   (cfg_q),
		.green (green)
	);

	pesc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (d_valid),
		.in_side   (d_side),
		.in_q      (d_q),
		.in_dzero  (d_dzero),
		.in_green  (green),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	// An empty output never holds back the input side.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output register");

	// Fluid results carry no color.
	a_fluid_green_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.green_valid) |-> (out_data.green == 32'sd0))
		else $error("green set on a fluid particle");

	// The dead flag agrees with the delivered life.
	a_dead_matches_life: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.dead == (out_data.new_life <= 32'sd0)))
		else $error("dead flag disagrees with new life");

endmodule

`default_nettype wire

// File: rtl/core/pesc_front.sv
// Front stages: Euler motion, forces, life update and the sphere range test.
// Depends on pesc_pkg.
`default_nettype none

module pesc_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire                   in_valid,
	input  wire pesc_pkg::in_t    in_data,
	input  wire pesc_pkg::cfg_t   cfg,
	output logic                  out_valid,
	output pesc_pkg::side_t       out_side,
	output logic [63:0]           out_sum,
	output logic [31:0]           out_life
);

	logic signed [31:0] pin [3];
	logic signed [31:0] vin [3];
	logic signed [31:0] cen [3];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic [31:0]        pos_s1 [3];
	logic [31:0]        vel_s1 [3];
	logic [31:0]        life_s1;
	logic signed [49:0] mv_s1 [3];
	logic signed [49:0] dmp_s1 [2];
	logic signed [39:0] fz_s1;

	logic [31:0] p_s2 [3];
	logic [31:0] v_s2 [3];
	logic [31:0] life_s2;
	logic [31:0] nl_s2;
	logic        dead_s2;

	pesc_pkg::side_t side_s3, side_s4, side_s5;
	logic [32:0] mag_s3 [3];
	logic        coarse_s3, coarse_s4;
	logic [31:0] life_s3, life_s4, life_s5;

	logic [61:0] sq_s4 [3];
	logic [61:0] radsq_s4;
	logic [63:0] sum_s5;

	logic [31:0]        nl_c;
	logic signed [32:0] d_c [3];
	logic [32:0]        mag_c [3];
	logic               coarse_c;
	logic [63:0]        sum_c;

	assign pin[0] = in_data.px;
	assign pin[1] = in_data.py;
	assign pin[2] = in_data.pz;
	assign vin[0] = in_data.vx;
	assign vin[1] = in_data.vy;
	assign vin[2] = in_data.vz;
	assign cen[0] = cfg.obs_x;
	assign cen[1] = cfg.obs_y;
	assign cen[2] = cfg.obs_z;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stage 1: the products of velocity with dt, the force term and damping.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pos_s1[i] <= pin[i];
				vel_s1[i] <= vin[i];
				mv_s1[i]  <= vin[i] * $signed({1'b0, cfg.time_step});
			end
			for (int i = 0; i < 2; i++) begin
				dmp_s1[i] <= vin[i] * pesc_pkg::DAMP_Q;
			end
			fz_s1   <= (cfg.mode == pesc_pkg::MODE_SMOKE ? pesc_pkg::BUOY_Q
			           : pesc_pkg::GRAVITY_Q) * $signed({1'b0, cfg.time_step});
			life_s1 <= in_data.life_left;
		end
	end

	// Life after the step.
	assign nl_c = pesc_pkg::sat32(pesc_pkg::ext32(life_s1)
	                              - $signed(64'(cfg.time_step)));

	// Stage 2: moved position and updated velocity.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s2[i] <= pesc_pkg::sat32(pesc_pkg::ext32(pos_s1[i])
				                           + pesc_pkg::rnd16(mv_s1[i]));
			end
			for (int i = 0; i < 2; i++) begin
				v_s2[i] <= (cfg.mode == pesc_pkg::MODE_SMOKE)
				           ? pesc_pkg::sat32(pesc_pkg::rnd16(dmp_s1[i])) : vel_s1[i];
			end
			v_s2[2] <= pesc_pkg::sat32(pesc_pkg::ext32(vel_s1[2])
			                           + pesc_pkg::rnd16(fz_s1));
			nl_s2   <= nl_c;
			dead_s2 <= ($signed(nl_c) <= 32'sd0);
			life_s2 <= life_s1;
		end
	end

	// Offset from the sphere center and the per-axis range test.
	always_comb begin
		coarse_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			d_c[i]   = $signed({p_s2[i][31], p_s2[i]}) - $signed({cen[i][31], cen[i]});
			mag_c[i] = d_c[i][32] ? (~d_c[i] + 33'd1) : d_c[i];
			if (mag_c[i] > {2'b00, cfg.radius}) begin
				coarse_c = 1'b0;
			end
		end
	end

	// Stage 3: offsets.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				side_s3.p[i] <= p_s2[i];
				side_s3.v[i] <= v_s2[i];
				side_s3.d[i] <= d_c[i];
				mag_s3[i]    <= mag_c[i];
			end
			side_s3.new_life <= nl_s2;
			side_s3.dead     <= dead_s2;
			side_s3.hit      <= 1'b0;
			coarse_s3        <= coarse_c;
			life_s3          <= life_s2;
		end
	end

	// Stage 4: squares. Only needed when every offset is within the radius.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= mag_s3[i][30:0] * mag_s3[i][30:0];
			end
			radsq_s4  <= cfg.radius * cfg.radius;
			side_s4   <= side_s3;
			coarse_s4 <= coarse_s3;
			life_s4   <= life_s3;
		end
	end

	assign sum_c = 64'(sq_s4[0]) + 64'(sq_s4[1]) + 64'(sq_s4[2]);

	// Stage 5: squared distance and the exact sphere test.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s5.p        <= side_s4.p;
			side_s5.v        <= side_s4.v;
			side_s5.d        <= side_s4.d;
			side_s5.new_life <= side_s4.new_life;
			side_s5.dead     <= side_s4.dead;
			side_s5.hit      <= coarse_s4 && (sum_c <= 64'(radsq_s4));
			sum_s5           <= sum_c;
			life_s5          <= life_s4;
		end
	end

	assign out_valid = vld_s5;
	assign out_side  = side_s5;
	assign out_sum   = sum_s5;
	assign out_life  = life_s5;

endmodule

`default_nettype wire

// File: rtl/core/pesc_sqrt.sv
// Pipelined integer square root of the squared distance, one root bit per
// stage. Carries the particle state alongside. Depends on pesc_pkg.
`default_nettype none

module pesc_sqrt (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  wire                    in_valid,
	input  wire pesc_pkg::side_t   in_side,
	input  wire [63:0]             in_sum,
	output logic                   out_valid,
	output pesc_pkg::side_t        out_side,
	output logic [31:0]            out_dis
);

	localparam int N = pesc_pkg::SQRT_STEPS;

	logic            vld_s  [N];
	logic [63:0]     x_s    [N];
	logic [63:0]     r_s    [N];
	pesc_pkg::side_t side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);

		logic            vld_p;
		logic [63:0]     x_p, r_p, trial, x_n, r_n;
		pesc_pkg::side_t side_p;

		if (k == 0) begin : g_first
			assign vld_p  = in_valid;
			assign x_p    = in_sum;
			assign r_p    = '0;
			assign side_p = in_side;
		end else begin : g_next
			assign vld_p  = vld_s[k-1];
			assign x_p    = x_s[k-1];
			assign r_p    = r_s[k-1];
			assign side_p = side_s[k-1];
		end

		// One trial subtraction of the digit-by-digit root.
		always_comb begin
			trial = r_p + BIT;
			if (x_p >= trial) begin
				x_n = x_p - trial;
				r_n = (r_p >> 1) + BIT;
			end else begin
				x_n = x_p;
				r_n = r_p >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= x_n;
				r_s[k]    <= r_n;
				side_s[k] <= side_p;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_side  = side_s[N-1];
	assign out_dis   = r_s[N-1][31:0];

endmodule

`default_nettype wire

// File: rtl/core/pesc_ndiv.sv
// Pipelined restoring divider for the unit normal: three lanes compute
// |d_i| * 2^16 / dis, one quotient bit per stage. Depends on pesc_pkg.
`default_nettype none

module pesc_ndiv (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  wire                    in_valid,
	input  wire pesc_pkg::side_t   in_side,
	input  wire [31:0]             in_dis,
	output logic                   out_valid,
	output pesc_pkg::side_t        out_side,
	output logic [2:0][16:0]       out_q,
	output logic                   out_dzero
);

	localparam int N = pesc_pkg::NDIV_STEPS;

	logic             vld_s  [N];
	logic [2:0][48:0] rem_s  [N];
	logic [2:0][16:0] q_s    [N];
	logic [31:0]      dis_s  [N];
	logic             dz_s   [N];
	pesc_pkg::side_t  side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int SH = N - 1 - k;

		logic             vld_p, dz_p;
		logic [31:0]      dis_p;
		logic [2:0][48:0] rem_p, rem_n;
		logic [2:0][16:0] q_p, q_n;
		logic [48:0]      dsh;
		pesc_pkg::side_t  side_p;

		if (k == 0) begin : g_first
			logic [32:0] mag [3];
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					mag[i]   = in_side.d[i][32] ? (~in_side.d[i] + 33'd1) : in_side.d[i];
					rem_p[i] = {mag[i], 16'd0};
					q_p[i]   = '0;
				end
			end
			assign vld_p  = in_valid;
			assign dis_p  = in_dis;
			assign dz_p   = (in_dis == 32'd0);
			assign side_p = in_side;
		end else begin : g_next
			assign vld_p  = vld_s[k-1];
			assign dis_p  = dis_s[k-1];
			assign dz_p   = dz_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign q_p    = q_s[k-1];
			assign side_p = side_s[k-1];
		end

		assign dsh = {17'd0, dis_p} << SH;

		// Trial subtraction of the shifted divisor in each lane.
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				if (rem_p[i] >= dsh) begin
					rem_n[i] = rem_p[i] - dsh;
					q_n[i]   = q_p[i] | (17'd1 << SH);
				end else begin
					rem_n[i] = rem_p[i];
					q_n[i]   = q_p[i];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_n;
				q_s[k]    <= q_n;
				dis_s[k]  <= dis_p;
				dz_s[k]   <= dz_p;
				side_s[k] <= side_p;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_side  = side_s[N-1];
	assign out_q     = q_s[N-1];
	assign out_dzero = dz_s[N-1];

endmodule

`default_nettype wire

// File: rtl/core/pesc_gdiv.sv
// Pipelined restoring divider for the smoke color: life * 2^16 / lifespan,
// truncated and saturated. One quotient bit per stage. Depends on pesc_pkg.
`default_nettype none

module pesc_gdiv (
	input  wire                  clk,
	input  wire                  en,
	input  wire [31:0]           life,
	input  wire pesc_pkg::cfg_t  cfg,
	output logic [31:0]          green
);

	localparam int N = pesc_pkg::GDIV_STEPS;

	logic [31:0] rem_s [N];
	logic [47:0] q_s   [N];
	logic [47:0] dvd_s [N];
	logic        neg_s [N];
	logic        pos_s [N];
	logic [31:0] green_q;

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int BI = N - 1 - k;

		logic [31:0] rem_p, rem_sh, rem_n;
		logic [47:0] q_p, q_n, dvd_p;
		logic        neg_p, pos_p;

		if (k == 0) begin : g_first
			logic [31:0] mag;
			assign mag   = life[31] ? (~life + 32'd1) : life;
			assign dvd_p = {mag, 16'd0};
			assign rem_p = '0;
			assign q_p   = '0;
			assign neg_p = life[31];
			assign pos_p = !life[31] && (life != 32'd0);
		end else begin : g_next
			assign dvd_p = dvd_s[k-1];
			assign rem_p = rem_s[k-1];
			assign q_p   = q_s[k-1];
			assign neg_p = neg_s[k-1];
			assign pos_p = pos_s[k-1];
		end

		// Shift in the next dividend bit and try the subtraction.
		always_comb begin
			rem_sh = {rem_p[30:0], dvd_p[BI]};
			if (rem_sh >= {1'b0, cfg.lifespan}) begin
				rem_n = rem_sh - {1'b0, cfg.lifespan};
				q_n   = q_p | (48'd1 << BI);
			end else begin
				rem_n = rem_sh;
				q_n   = q_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_n;
				q_s[k]   <= q_n;
				dvd_s[k] <= dvd_p;
				neg_s[k] <= neg_p;
				pos_s[k] <= pos_p;
			end
		end
	end

	// Sign, saturation and the zero lifespan case.
	always_ff @(posedge clk) begin
		if (en) begin
			if (cfg.lifespan == 31'd0) begin
				green_q <= pos_s[N-1] ? pesc_pkg::SAT_MAX
				         : (neg_s[N-1] ? pesc_pkg::SAT_MIN : 32'd0);
			end else if (!neg_s[N-1]) begin
				green_q <= (q_s[N-1] > 48'h0000_7fff_ffff) ? pesc_pkg::SAT_MAX
				         : q_s[N-1][31:0];
			end else begin
				green_q <= (q_s[N-1] > 48'h0000_8000_0000) ? pesc_pkg::SAT_MIN
				         : (~q_s[N-1][31:0] + 32'd1);
			end
		end
	end

	assign green = green_q;

endmodule

`default_nettype wire

// File: rtl/core/pesc_back.sv
// Back stages: normal, push-out to the sphere surface, fluid reflection and
// the output register. Depends on pesc_pkg.
`default_nettype none

module pesc_back (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  wire                    in_valid,
	input  wire pesc_pkg::side_t   in_side,
	input  wire [2:0][16:0]        in_q,
	input  wire                    in_dzero,
	input  wire [31:0]             in_green,
	input  wire pesc_pkg::cfg_t    cfg,
	output logic                   out_valid,
	output pesc_pkg::out_t         out_data
);

	logic signed [31:0] cen [3];
	logic signed [17:0] n_c [3];
	logic signed [32:0] prad;

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic signed [17:0] n_s1 [3];
	logic signed [50:0] push_s1 [3];
	logic signed [49:0] vn_s1 [3];
	pesc_pkg::side_t    side_s1, side_s2, side_s3;
	logic [31:0]        green_s1, green_s2, green_s3;

	logic signed [17:0] n_s2 [3];
	logic [31:0]        pp_s2 [3];
	logic signed [35:0] dot_s2;

	logic [31:0]        pp_s3 [3];
	logic signed [53:0] t_s3 [3];

	pesc_pkg::out_t data_s4;

	logic signed [63:0] vsum_c, dot_c;
	logic signed [63:0] t2_c [3];
	logic signed [63:0] w_c [3];
	logic [31:0]        hv_c [3];
	logic               reflect_c;
	pesc_pkg::out_t     res_c;

	assign cen[0] = cfg.obs_x;
	assign cen[1] = cfg.obs_y;
	assign cen[2] = cfg.obs_z;
	assign prad   = $signed({2'b00, cfg.radius}) + pesc_pkg::PUSH_Q;

	// Signed normal; a zero distance points straight up.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (in_dzero) begin
				n_c[i] = (i == 2) ? pesc_pkg::ONE_Q : 18'sd0;
			end else if (in_side.d[i][32]) begin
				n_c[i] = -$signed({1'b0, in_q[i]});
			end else begin
				n_c[i] = $signed({1'b0, in_q[i]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Stage 1: push distance and velocity terms along the normal.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_s1[i]    <= n_c[i];
				push_s1[i] <= n_c[i] * prad;
				vn_s1[i]   <= n_c[i] * $signed(in_side.v[i]);
			end
			side_s1  <= in_side;
			green_s1 <= in_green;
		end
	end

	assign vsum_c = vn_s1[0] + vn_s1[1] + vn_s1[2];
	assign dot_c  = pesc_pkg::rnd16(vsum_c);

	// Stage 2: pushed position and the dot product.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_s2[i]  <= n_s1[i];
				pp_s2[i] <= pesc_pkg::sat32(pesc_pkg::ext32(cen[i])
				                            + pesc_pkg::rnd16(push_s1[i]));
			end
			dot_s2   <= dot_c[35:0];
			side_s2  <= side_s1;
			green_s2 <= green_s1;
		end
	end

	// Stage 3: dot times normal.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				t_s3[i]  <= dot_s2 * n_s2[i];
				pp_s3[i] <= pp_s2[i];
			end
			side_s3  <= side_s2;
			green_s3 <= green_s2;
		end
	end

	// Reflected and halved velocity, then selection of the result.
	always_comb begin
		reflect_c = side_s3.hit && (cfg.mode != pesc_pkg::MODE_SMOKE);
		for (int i = 0; i < 3; i++) begin
			t2_c[i] = t_s3[i];
			t2_c[i] = t2_c[i] <<< 1;
			w_c[i]  = pesc_pkg::ext32(side_s3.v[i]) - pesc_pkg::rnd16(t2_c[i]);
			hv_c[i] = pesc_pkg::sat32((w_c[i] + 64'sd1) >>> 1);
		end
		res_c.new_px      = side_s3.hit ? pp_s3[0] : side_s3.p[0];
		res_c.new_py      = side_s3.hit ? pp_s3[1] : side_s3.p[1];
		res_c.new_pz      = side_s3.hit ? pp_s3[2] : side_s3.p[2];
		res_c.new_vx      = reflect_c ? hv_c[0] : side_s3.v[0];
		res_c.new_vy      = reflect_c ? hv_c[1] : side_s3.v[1];
		res_c.new_vz      = reflect_c ? hv_c[2] : side_s3.v[2];
		res_c.new_life    = side_s3.new_life;
		res_c.green       = (cfg.mode == pesc_pkg::MODE_SMOKE) ? green_s3 : 32'd0;
		res_c.green_valid = (cfg.mode == pesc_pkg::MODE_SMOKE);
		res_c.dead        = side_s3.dead;
		res_c.collided    = side_s3.hit;
	end

	// Stage 4: output register.
	always_ff @(posedge clk) begin
		if (en) begin
			data_s4 <= res_c;
		end
	end

	assign out_valid = vld_s4;
	assign out_data  = data_s4;

endmodule

`default_nettype wire
